[src/flfm_pkg.sv]
package flfm_pkg;

    // Field widths fixed by the interface.
    localparam int BYTE_W   = 8;
    localparam int PL_W     = 7;
    localparam int LEN_W    = 3;
    localparam int LEN_EFF_W = 4;
    localparam int MARK_W   = 32;
    localparam int CNT_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Number of bytes held in one header or footer register.
    localparam int MARK_BYTES = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = 16'hffff;
    localparam logic [PL_W-1:0]  PACKET_LENGTH_RESET = 7'd64;

    // Defaults for the top-level parameters.
    localparam int WINDOW_DEPTH_DEF = 64;
    localparam int MARK_MAX_DEF     = 4;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_PACKET_LENGTH = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_BYTES  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_HEADER_LENGTH = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FOOTER_BYTES  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_FOOTER_LENGTH = 3'd4;

    typedef enum logic [1:0] {
        VERDICT_WAIT       = 2'd0,
        VERDICT_BAD_FOOTER = 2'd1,
        VERDICT_BAD_HEADER = 2'd2,
        VERDICT_GOOD       = 2'd3
    } t_verdict;

    // Configuration after clamping, as the compare logic uses it.
    typedef struct packed {
        logic [PL_W-1:0]      packet_length;
        logic [LEN_EFF_W-1:0] header_length;
        logic [LEN_EFF_W-1:0] footer_length;
        logic [MARK_W-1:0]    header_bytes;
        logic [MARK_W-1:0]    footer_bytes;
    } t_cfg;

    // One verdict.
    typedef struct packed {
        t_verdict         verdict;
        logic [PL_W-1:0]  bytes_wanted;
        logic [CNT_W-1:0] frame_offset;
        logic [CNT_W-1:0] bytes_seen;
    } t_result;

    // Handshake state shared between the top level and the window.
    typedef struct packed {
        logic accept;
        logic s1_valid;
        logic s1_move;
        logic s1_good;
    } t_pipe_ctl;

    // Byte pos of a mark sequence; positions past the register read as zero.
    function automatic logic [BYTE_W-1:0] mark_byte(input logic [MARK_W-1:0] seq,
                                                    input logic [LEN_EFF_W-1:0] pos);
        logic [BYTE_W-1:0] result;
        if (pos >= LEN_EFF_W'(MARK_BYTES)) begin
            result = '0;
        end else begin
            result = seq[{pos[1:0], 3'b000} +: BYTE_W];
        end
        return result;
    endfunction

endpackage

[src/fixed_length_frame_matcher.sv]
// Fixed-length frame matcher.
// Received bytes enter on the input channel (i_valid, o_stall, i_data_byte,
// i_start_of_read), one request per byte. Every byte gives exactly one verdict
// on the output channel (o_valid, i_stall, o_verdict, o_bytes_wanted,
// o_frame_offset, o_bytes_seen): waiting, bad footer, bad header or good frame.
// A byte with i_start_of_read high restarts the byte count; after a good frame
// the next byte restarts it as well.
// Throughput is one byte per cycle while the receiver does not stall: the
// byte enters the window stage, the footer and header compares run on its
// contents, and the verdict is registered into the output register once that
// register is free and is held there. When the receiver stalls, the held
// verdict stays put and one more byte can still enter the window stage;
// o_stall rises only when both stages are full.
// Configuration is written through i_cfg_wr_en, i_cfg_index and i_cfg_data
// while no byte is in flight. Reset clears the byte count, the restart flag and
// both channels, and returns the registers to their defaults (packet length 64,
// empty header and footer). The window contents are not cleared.
module fixed_length_frame_matcher #(
    parameter int WINDOW_DEPTH = flfm_pkg::WINDOW_DEPTH_DEF,
    parameter int MARK_MAX     = flfm_pkg::MARK_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration port.
    input  logic                            i_cfg_wr_en,
    input  logic [flfm_pkg::CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [flfm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // Input channel.
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [flfm_pkg::BYTE_W-1:0]     i_data_byte,
    input  logic                            i_start_of_read,
    // Output channel.
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [1:0]                      o_verdict,
    output logic [flfm_pkg::PL_W-1:0]       o_bytes_wanted,
    output logic [flfm_pkg::CNT_W-1:0]      o_frame_offset,
    output logic [flfm_pkg::CNT_W-1:0]      o_bytes_seen
);

    flfm_pkg::t_cfg                            w_cfg;
    flfm_pkg::t_pipe_ctl                       w_ctl;
    flfm_pkg::t_result                         w_result;
    flfm_pkg::t_result                         r_out;
    logic                                      r_s1_valid;
    logic                                      n_s1_valid;
    logic                                      r_out_valid;
    logic                                      n_out_valid;
    logic                                      w_out_free;
    logic [flfm_pkg::CNT_W-1:0]                w_count;
    logic [MARK_MAX-1:0][flfm_pkg::BYTE_W-1:0] w_recent;
    logic [MARK_MAX-1:0][flfm_pkg::BYTE_W-1:0] w_rd;

    flfm_cfg #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MARK_MAX     (MARK_MAX)
    ) u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // Handshake: the output register frees up when empty or taken; the window
    // stage moves into it then, and takes a new request when it is empty or moving.
    assign w_out_free     = !r_out_valid || !i_stall;
    assign w_ctl.s1_valid = r_s1_valid;
    assign w_ctl.s1_move  = r_s1_valid && w_out_free;
    assign w_ctl.s1_good  = (w_result.verdict == flfm_pkg::VERDICT_GOOD);
    assign o_stall        = r_s1_valid && !w_out_free;
    assign w_ctl.accept   = i_valid && !o_stall;

    flfm_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MARK_MAX     (MARK_MAX)
    ) u_window (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctl           (w_ctl),
        .i_data_byte     (i_data_byte),
        .i_start_of_read (i_start_of_read),
        .i_packet_length (w_cfg.packet_length),
        .o_count         (w_count),
        .o_recent        (w_recent),
        .o_rd            (w_rd)
    );

    flfm_judge #(
        .MARK_MAX (MARK_MAX)
    ) u_judge (
        .i_cfg    (w_cfg),
        .i_count  (w_count),
        .i_recent (w_recent),
        .i_rd     (w_rd),
        .o_result (w_result)
    );

    // Stage occupancy.
    always_comb begin
        if (w_ctl.accept) begin
            n_s1_valid = 1'b1;
        end else if (w_ctl.s1_move) begin
            n_s1_valid = 1'b0;
        end else begin
            n_s1_valid = r_s1_valid;
        end

        if (w_ctl.s1_move) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_ctl.s1_move) begin
            r_out <= w_result;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_verdict      = r_out.verdict;
    assign o_bytes_wanted = r_out.bytes_wanted;
    assign o_frame_offset = r_out.frame_offset;
    assign o_bytes_seen   = r_out.bytes_seen;

`ifndef SYNTH
    // A byte that follows a good frame straight away starts a new count.
    a_restart_after_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.s1_move && w_ctl.s1_good && w_ctl.accept) |=> (w_count == 16'd1))
        else $error("count did not restart after a good frame");

    // Every verdict counts at least its own byte.
    a_seen_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_bytes_seen != '0))
        else $error("verdict with zero bytes seen");

    // A good frame starts one packet length before the current count.
    a_good_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_verdict == flfm_pkg::VERDICT_GOOD)) |->
        ((o_frame_offset + flfm_pkg::CNT_W'(w_cfg.packet_length) == o_bytes_seen) &&
         (o_bytes_wanted == '0)))
        else $error("good frame offset inconsistent with count");

    // Only a good frame carries an offset.
    a_offset_only_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_verdict != flfm_pkg::VERDICT_GOOD)) |-> (o_frame_offset == '0))
        else $error("offset on a verdict other than good");

    // The input side stalls only when both stages hold a byte.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_s1_valid && r_out_valid && i_stall))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

[src/flfm_window_ram.sv]
module flfm_window_ram #(
    parameter int DEPTH = flfm_pkg::WINDOW_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                        i_clk,
    input  logic                        i_wr_en,
    input  logic [AW-1:0]               i_wr_addr,
    input  logic [flfm_pkg::BYTE_W-1:0] i_wr_data,
    input  logic                        i_rd_en,
    input  logic [AW-1:0]               i_rd_addr,
    output logic [flfm_pkg::BYTE_W-1:0] o_rd_data
);

    logic [flfm_pkg::BYTE_W-1:0] r_mem [DEPTH];
    logic [flfm_pkg::BYTE_W-1:0] r_rd_data;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // One registered read port; a read returns the contents before any same-edge write.
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[src/flfm_cfg.sv]
module flfm_cfg #(
    parameter int WINDOW_DEPTH = flfm_pkg::WINDOW_DEPTH_DEF,
    parameter int MARK_MAX     = flfm_pkg::MARK_MAX_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_wr_en,
    input  logic [flfm_pkg::CFG_ADDR_W-1:0] i_cfg_index,
    input  logic [flfm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output flfm_pkg::t_cfg                  o_cfg
);

    logic [flfm_pkg::PL_W-1:0]      r_packet_length;
    logic [flfm_pkg::MARK_W-1:0]    r_header_bytes;
    logic [flfm_pkg::LEN_W-1:0]     r_header_length;
    logic [flfm_pkg::MARK_W-1:0]    r_footer_bytes;
    logic [flfm_pkg::LEN_W-1:0]     r_footer_length;

    logic [flfm_pkg::PL_W-1:0]      w_pl;
    logic [flfm_pkg::LEN_EFF_W-1:0] w_hl_mark;
    logic [flfm_pkg::LEN_EFF_W-1:0] w_hl;
    logic [flfm_pkg::LEN_EFF_W-1:0] w_fl;

    // Register writes; indexes past the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packet_length <= flfm_pkg::PACKET_LENGTH_RESET;
            r_header_bytes  <= '0;
            r_header_length <= '0;
            r_footer_bytes  <= '0;
            r_footer_length <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                flfm_pkg::REG_PACKET_LENGTH: begin
                    r_packet_length <= i_cfg_data[flfm_pkg::PL_W-1:0];
                end
                flfm_pkg::REG_HEADER_BYTES: begin
                    r_header_bytes <= i_cfg_data[flfm_pkg::MARK_W-1:0];
                end
                flfm_pkg::REG_HEADER_LENGTH: begin
                    r_header_length <= i_cfg_data[flfm_pkg::LEN_W-1:0];
                end
                flfm_pkg::REG_FOOTER_BYTES: begin
                    r_footer_bytes <= i_cfg_data[flfm_pkg::MARK_W-1:0];
                end
                flfm_pkg::REG_FOOTER_LENGTH: begin
                    r_footer_length <= i_cfg_data[flfm_pkg::LEN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Clamp the lengths: a zero packet length means one byte, and the packet
    // cannot be longer than the window; marks cannot exceed MARK_MAX bytes,
    // and the header cannot be longer than the packet.
    always_comb begin
        if (r_packet_length == '0) begin
            w_pl = flfm_pkg::PL_W'(1);
        end else if (int'(r_packet_length) > WINDOW_DEPTH) begin
            w_pl = flfm_pkg::PL_W'(WINDOW_DEPTH);
        end else begin
            w_pl = r_packet_length;
        end

        if (int'(r_footer_length) > MARK_MAX) begin
            w_fl = flfm_pkg::LEN_EFF_W'(MARK_MAX);
        end else begin
            w_fl = {1'b0, r_footer_length};
        end

        if (int'(r_header_length) > MARK_MAX) begin
            w_hl_mark = flfm_pkg::LEN_EFF_W'(MARK_MAX);
        end else begin
            w_hl_mark = {1'b0, r_header_length};
        end

        if (flfm_pkg::PL_W'(w_hl_mark) > w_pl) begin
            w_hl = w_pl[flfm_pkg::LEN_EFF_W-1:0];
        end else begin
            w_hl = w_hl_mark;
        end
    end

    assign o_cfg.packet_length = w_pl;
    assign o_cfg.header_length = w_hl;
    assign o_cfg.footer_length = w_fl;
    assign o_cfg.header_bytes  = r_header_bytes;
    assign o_cfg.footer_bytes  = r_footer_bytes;

endmodule

[src/flfm_window.sv]
module flfm_window #(
    parameter int WINDOW_DEPTH = flfm_pkg::WINDOW_DEPTH_DEF,
    parameter int MARK_MAX     = flfm_pkg::MARK_MAX_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  flfm_pkg::t_pipe_ctl                        i_ctl,
    input  logic [flfm_pkg::BYTE_W-1:0]                i_data_byte,
    input  logic                                       i_start_of_read,
    input  logic [flfm_pkg::PL_W-1:0]                  i_packet_length,
    output logic [flfm_pkg::CNT_W-1:0]                 o_count,
    output logic [MARK_MAX-1:0][flfm_pkg::BYTE_W-1:0]  o_recent,
    output logic [MARK_MAX-1:0][flfm_pkg::BYTE_W-1:0]  o_rd
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int CW = ((AW > flfm_pkg::PL_W) ? AW : flfm_pkg::PL_W) + 1;

    logic [flfm_pkg::CNT_W-1:0]                r_count;
    logic [flfm_pkg::CNT_W-1:0]                n_count;
    logic                                      r_restart;
    logic                                      n_restart;
    logic                                      w_restart_in;
    logic [AW-1:0]                             r_wp;
    logic [AW-1:0]                             n_wp;
    logic [MARK_MAX-1:0][flfm_pkg::BYTE_W-1:0] r_recent;

    // A good verdict still in the compare stage has not reached r_restart yet.
    assign w_restart_in = i_ctl.s1_valid ? i_ctl.s1_good : r_restart;

    // Byte count and restart flag for the next request.
    always_comb begin
        if (i_start_of_read || w_restart_in) begin
            n_count = flfm_pkg::CNT_W'(1);
        end else if (r_count == flfm_pkg::COUNT_MAX) begin
            n_count = r_count;
        end else begin
            n_count = r_count + 1'b1;
        end

        if (i_ctl.accept) begin
            n_restart = 1'b0;
        end else if (i_ctl.s1_move) begin
            n_restart = i_ctl.s1_good;
        end else begin
            n_restart = r_restart;
        end

        if (r_wp == AW'(WINDOW_DEPTH - 1)) begin
            n_wp = '0;
        end else begin
            n_wp = r_wp + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_restart <= 1'b0;
            r_wp      <= '0;
        end else begin
            r_restart <= n_restart;
            if (i_ctl.accept) begin
                r_count <= n_count;
                r_wp    <= n_wp;
            end
        end
    end

    // The newest bytes in flip-flops for the footer compare.
    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_recent[0] <= i_data_byte;
            for (int j = 1; j < MARK_MAX; j++) begin
                r_recent[j] <= r_recent[j-1];
            end
        end
    end

    // One window copy per header position, each read one less than a packet
    // length back from the new byte, less the header position.
    for (genvar g = 0; g < MARK_MAX; g++) begin : g_lane
        logic [CW-1:0] w_back;
        logic [CW-1:0] w_addr_full;
        logic [AW-1:0] w_rd_addr;

        always_comb begin
            if (i_packet_length > flfm_pkg::PL_W'(g)) begin
                w_back = CW'(i_packet_length) - CW'(g) - CW'(1);
            end else begin
                w_back = '0;
            end
            if (CW'(n_wp) >= w_back) begin
                w_addr_full = CW'(n_wp) - w_back;
            end else begin
                w_addr_full = CW'(n_wp) + CW'(WINDOW_DEPTH) - w_back;
            end
        end

        assign w_rd_addr = w_addr_full[AW-1:0];

        flfm_window_ram #(
            .DEPTH (WINDOW_DEPTH)
        ) u_ram (
            .i_clk     (i_clk),
            .i_wr_en   (i_ctl.accept),
            .i_wr_addr (n_wp),
            .i_wr_data (i_data_byte),
            .i_rd_en   (i_ctl.accept),
            .i_rd_addr (w_rd_addr),
            .o_rd_data (o_rd[g])
        );
    end

    assign o_count  = r_count;
    assign o_recent = r_recent;

endmodule

[src/flfm_judge.sv]
module flfm_judge #(
    parameter int MARK_MAX = flfm_pkg::MARK_MAX_DEF
) (
    input  flfm_pkg::t_cfg                             i_cfg,
    input  logic [flfm_pkg::CNT_W-1:0]                 i_count,
    input  logic [MARK_MAX-1:0][flfm_pkg::BYTE_W-1:0]  i_recent,
    input  logic [MARK_MAX-1:0][flfm_pkg::BYTE_W-1:0]  i_rd,
    output flfm_pkg::t_result                          o_result
);

    logic [MARK_MAX-1:0]        w_foot_ok;
    logic [MARK_MAX-1:0]        w_head_ok;
    logic [flfm_pkg::CNT_W-1:0] w_pl16;

    assign w_pl16 = flfm_pkg::CNT_W'(i_cfg.packet_length);

    // Per-position compares; positions past the mark length always pass.
    for (genvar g = 0; g < MARK_MAX; g++) begin : g_cmp
        logic [flfm_pkg::LEN_EFF_W-1:0] w_foot_pos;
        logic [flfm_pkg::BYTE_W-1:0]    w_head_byte;

        // The footer is aligned so that its last byte is the newest byte.
        assign w_foot_pos = i_cfg.footer_length - flfm_pkg::LEN_EFF_W'(g)
                            - flfm_pkg::LEN_EFF_W'(1);

        // When the header reaches the newest byte, the window read misses it.
        assign w_head_byte = (i_cfg.packet_length == flfm_pkg::PL_W'(g + 1)) ?
                             i_recent[0] : i_rd[g];

        assign w_foot_ok[g] = (flfm_pkg::LEN_EFF_W'(g) >= i_cfg.footer_length) ||
            (i_recent[g] == flfm_pkg::mark_byte(i_cfg.footer_bytes, w_foot_pos));

        assign w_head_ok[g] = (flfm_pkg::LEN_EFF_W'(g) >= i_cfg.header_length) ||
            (w_head_byte == flfm_pkg::mark_byte(i_cfg.header_bytes,
                                                flfm_pkg::LEN_EFF_W'(g)));
    end

    // Verdict selection.
    always_comb begin
        o_result.bytes_seen   = i_count;
        o_result.frame_offset = '0;
        if ((i_count <= flfm_pkg::CNT_W'(i_cfg.footer_length)) || (i_count < w_pl16)) begin
            o_result.verdict = flfm_pkg::VERDICT_WAIT;
            if (w_pl16 > i_count) begin
                o_result.bytes_wanted = flfm_pkg::PL_W'(w_pl16 - i_count);
            end else begin
                o_result.bytes_wanted = '0;
            end
        end else if (!(&w_foot_ok)) begin
            o_result.verdict      = flfm_pkg::VERDICT_BAD_FOOTER;
            o_result.bytes_wanted = flfm_pkg::PL_W'(i_cfg.footer_length);
        end else if (!(&w_head_ok)) begin
            o_result.verdict      = flfm_pkg::VERDICT_BAD_HEADER;
            o_result.bytes_wanted = i_cfg.packet_length;
        end else begin
            o_result.verdict      = flfm_pkg::VERDICT_GOOD;
            o_result.bytes_wanted = '0;
            o_result.frame_offset = i_count - w_pl16;
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import flfm_pkg::*;

    localparam int WINDOW     = WINDOW_DEPTH_DEF;
    localparam int MARK_LIMIT = MARK_MAX_DEF;
    localparam int REPORT_MAX = 10;

    // First index past the register list; writes there must be ignored.
    localparam logic [CFG_ADDR_W-1:0] REG_SPARE_FIRST = REG_FOOTER_LENGTH + 3'd1;

    // Tracks the matcher state and holds the verdicts still owed by the block.
    class frame_verdict_scoreboard;
        logic [PL_W-1:0]    pkt_len;
        logic [MARK_W-1:0]  head_seq;
        logic [LEN_W-1:0]   head_len;
        logic [MARK_W-1:0]  foot_seq;
        logic [LEN_W-1:0]   foot_len;
        logic [CNT_W-1:0]   seen;
        logic [BYTE_W-1:0]  window [WINDOW];
        bit                 restart_due;
        t_result            pending_verdicts [$];
        int                 mismatch_count;

        function new();
            pkt_len     = PACKET_LENGTH_RESET;
            head_seq    = '0;
            head_len    = '0;
            foot_seq    = '0;
            foot_len    = '0;
            seen        = '0;
            restart_due = 1'b0;
            mismatch_count = 0;
            foreach (window[k]) window[k] = '0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PACKET_LENGTH: pkt_len  = data[PL_W-1:0];
                REG_HEADER_BYTES:  head_seq = data;
                REG_HEADER_LENGTH: head_len = data[LEN_W-1:0];
                REG_FOOTER_BYTES:  foot_seq = data;
                REG_FOOTER_LENGTH: foot_len = data[LEN_W-1:0];
                default: ;
            endcase
        endfunction

        // Packet length as the compare uses it: zero means one, capped at the window.
        function int pkt_span();
            if (pkt_len == '0) return 1;
            return (int'(pkt_len) > WINDOW) ? WINDOW : int'(pkt_len);
        endfunction

        function int foot_span();
            return (int'(foot_len) > MARK_LIMIT) ? MARK_LIMIT : int'(foot_len);
        endfunction

        function int head_span();
            int h;
            h = (int'(head_len) > MARK_LIMIT) ? MARK_LIMIT : int'(head_len);
            return (h > pkt_span()) ? pkt_span() : h;
        endfunction

        function int pending();
            return pending_verdicts.size();
        endfunction

        // Advances the state by one accepted byte and queues the verdict it owes.
        function void accept_byte(logic [BYTE_W-1:0] data, bit start);
            t_result r;
            int pl, fl, hl, k;
            bit ok;
            if (start || restart_due) seen = '0;
            restart_due = 1'b0;
            for (k = WINDOW - 1; k > 0; k--) window[k] = window[k-1];
            window[0] = data;
            if (seen != COUNT_MAX) seen++;
            pl = pkt_span();
            fl = foot_span();
            hl = head_span();
            r = '0;
            r.bytes_seen = seen;
            if (int'(seen) <= fl || int'(seen) < pl) begin
                r.verdict = VERDICT_WAIT;
                r.bytes_wanted = (pl > int'(seen)) ? PL_W'(pl - int'(seen)) : '0;
            end else begin
                ok = 1'b1;
                // Newest byte pairs with the last footer byte.
                for (k = 0; k < fl; k++) begin
                    if (window[k] != foot_seq[8*(fl-1-k) +: 8]) ok = 1'b0;
                end
                if (!ok) begin
                    r.verdict = VERDICT_BAD_FOOTER;
                    r.bytes_wanted = PL_W'(fl);
                end else begin
                    for (k = 0; k < hl; k++) begin
                        if (window[pl-1-k] != head_seq[8*k +: 8]) ok = 1'b0;
                    end
                    if (!ok) begin
                        r.verdict = VERDICT_BAD_HEADER;
                        r.bytes_wanted = PL_W'(pl);
                    end else begin
                        r.verdict = VERDICT_GOOD;
                        r.frame_offset = seen - CNT_W'(pl);
                        restart_due = 1'b1;
                    end
                end
            end
            pending_verdicts.push_back(r);
        endfunction

        function void check_verdict(t_result got);
            t_result want;
            bit bad;
            if (pending_verdicts.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("Verdict %0d (seen %0d) arrived with no byte pending",
                             got.verdict, got.bytes_seen);
                return;
            end
            want = pending_verdicts.pop_front();
            bad = (got.verdict !== want.verdict) || (got.bytes_wanted !== want.bytes_wanted)
                || (got.frame_offset !== want.frame_offset)
                || (got.bytes_seen !== want.bytes_seen);
            if (bad) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_MAX)
                    $display("Verdict mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d %s",
                             want.verdict, want.bytes_wanted, want.frame_offset,
                             want.bytes_seen, got.verdict, got.bytes_wanted,
                             got.frame_offset, got.bytes_seen,
                             "(verdict/wanted/offset/seen)");
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    logic [BYTE_W-1:0]     i_data_byte = '0;
    logic                  i_start_of_read = 1'b0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    logic [1:0]            o_verdict;
    logic [PL_W-1:0]       o_bytes_wanted;
    logic [CNT_W-1:0]      o_frame_offset;
    logic [CNT_W-1:0]      o_bytes_seen;

    frame_verdict_scoreboard board;
    bit calm = 1'b0;

    fixed_length_frame_matcher u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_data_byte     (i_data_byte),
        .i_start_of_read (i_start_of_read),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_verdict       (o_verdict),
        .o_bytes_wanted  (o_bytes_wanted),
        .o_frame_offset  (o_frame_offset),
        .o_bytes_seen    (o_bytes_seen)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Idle length for either side: mostly none, sometimes short, rarely long.
    function automatic int pick_idle();
        int r;
        if (calm) return 0;
        r = $urandom_range(99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Sends one byte request and waits until the block takes it.
    task automatic send_byte(input logic [BYTE_W-1:0] data, input bit start);
        int gap;
        gap = pick_idle();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_data_byte     <= data;
        i_start_of_read <= start;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        board.accept_byte(data, start);
    endtask

    // Holds off the sender until every owed verdict has come back.
    task automatic wait_idle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Writes all five registers plus one unused index; short registers get
    // random upper bits now and then, which the block must drop.
    task automatic apply_config(input int pl, input logic [31:0] hs, input int hl,
                                input logic [31:0] fs, input int fl);
        logic [CFG_ADDR_W-1:0] idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        logic [31:0] junk;
        int k;
        junk = $urandom_range(1) ? $urandom : 32'd0;
        idx[0] = REG_PACKET_LENGTH; val[0] = {junk[31:PL_W], PL_W'(pl)};
        idx[1] = REG_HEADER_BYTES;  val[1] = hs;
        idx[2] = REG_HEADER_LENGTH; val[2] = {junk[31:LEN_W], LEN_W'(hl)};
        idx[3] = REG_FOOTER_BYTES;  val[3] = fs;
        idx[4] = REG_FOOTER_LENGTH; val[4] = {junk[31:LEN_W], LEN_W'(fl)};
        idx[5] = REG_SPARE_FIRST + CFG_ADDR_W'($urandom_range(2));
        val[5] = $urandom;
        for (k = 0; k < 6; k++) begin
            i_cfg_wr_en <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            board.write_reg(idx[k], val[k]);
        end
        i_cfg_wr_en <= 1'b0;
    endtask

    // Mostly well-formed frames for the current setting, some corrupted,
    // mixed with stray bytes and the odd restart.
    task automatic send_frames(input int n);
        logic [BYTE_W-1:0] frame [$];
        int sent, span, pl, fl, hl, r, k;
        bit lead_start;
        sent = 0;
        while (sent < n) begin
            r = $urandom_range(99);
            if (r < 12) begin
                send_byte(8'($urandom), $urandom_range(9) == 0);
                sent++;
            end else begin
                if (r < 16) wait_idle();
                pl = board.pkt_span();
                fl = board.foot_span();
                hl = board.head_span();
                // The footer check needs more bytes than its length.
                span = (pl > fl) ? pl : fl + 1;
                frame.delete();
                for (k = 0; k < span; k++) frame.push_back(8'($urandom));
                for (k = 0; k < hl; k++) frame[span-pl+k] = board.head_seq[8*k +: 8];
                for (k = 0; k < fl; k++) frame[span-fl+k] = board.foot_seq[8*k +: 8];
                if ($urandom_range(99) < 15) begin
                    k = $urandom_range(span - 1);
                    frame[k] = frame[k] ^ 8'($urandom_range(1, 255));
                end
                lead_start = $urandom_range(1);
                for (k = 0; k < span && sent < n; k++) begin
                    send_byte(frame[k], (k == 0) && lead_start);
                    sent++;
                end
            end
        end
    endtask

    task automatic run_phase(input int pl, input logic [31:0] hs, input int hl,
                             input logic [31:0] fs, input int fl, input int n);
        wait_idle();
        apply_config(pl, hs, hl, fs, fl);
        calm = ($urandom_range(3) == 0);
        send_frames(n);
    endtask

    // Result side: check every accepted verdict, stall at random.
    initial begin
        t_result got;
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                got.verdict      = t_verdict'(o_verdict);
                got.bytes_wanted = o_bytes_wanted;
                got.frame_offset = o_frame_offset;
                got.bytes_seen   = o_bytes_seen;
                board.check_verdict(got);
            end
            if (stall_left > 0) stall_left--;
            else if ($urandom_range(99) < 25) stall_left = pick_idle();
            i_stall <= (stall_left > 0);
        end
    end

    initial begin
        int p;
        board = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset values: 64-byte frames with no header or footer check.
        send_frames(110);

        // Six-byte frames, two-byte header and footer: good, bad footer,
        // bad header, then a restart in the middle of a frame.
        wait_idle();
        apply_config(6, 32'h0000_5AA5, 2, 32'h0000_0A0D, 2);
        calm = 1'b0;
        send_byte(8'hA5, 1'b1); send_byte(8'h5A, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'h0D, 1'b0); send_byte(8'h0A, 1'b0);
        send_byte(8'hA5, 1'b0); send_byte(8'h5A, 1'b0); send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0); send_byte(8'h0D, 1'b0); send_byte(8'h0B, 1'b0);
        send_byte(8'hA5, 1'b1); send_byte(8'h5B, 1'b0); send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0); send_byte(8'h0D, 1'b0); send_byte(8'h0A, 1'b0);
        send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b1);

        // Zero packet length acts as one; header length over the limit and
        // over the packet; footer longer than the packet keeps it waiting.
        wait_idle();
        apply_config(0, 32'h1234_56C3, 7, 32'hEEC3_2211, 3);
        send_byte(8'h11, 1'b1); send_byte(8'h22, 1'b0); send_byte(8'hC3, 1'b0);
        send_byte(8'h11, 1'b0); send_byte(8'h22, 1'b0); send_byte(8'hC3, 1'b0);
        send_byte(8'h00, 1'b0);

        for (p = 0; p < 10; p++) begin
            case (p)
                0: run_phase(1, $urandom, $urandom_range(7), $urandom, 0, 40);
                1: run_phase(64, $urandom, 4, $urandom, 4, 90);
                2: run_phase(127, $urandom, $urandom_range(5, 7), $urandom,
                             $urandom_range(5, 7), 60);
                3: run_phase(3, $urandom, 4, $urandom, 4, 40);
                4: run_phase($urandom_range(2, 20), 32'hFFFF_FFFF, $urandom_range(7),
                             32'h0000_0000, $urandom_range(7), 60);
                5: run_phase($urandom_range(2, 20), 32'h0000_0000, $urandom_range(7),
                             32'hFFFF_FFFF, $urandom_range(7), 60);
                default: run_phase(($urandom_range(3) == 0) ? $urandom_range(127)
                                                             : $urandom_range(2, 16),
                                   $urandom, $urandom_range(7), $urandom,
                                   $urandom_range(7), 45);
            endcase
        end
        calm = 1'b0;

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (board.mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #40_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
src/flfm_pkg.sv
src/flfm_window_ram.sv
src/flfm_cfg.sv
src/flfm_window.sv
src/flfm_judge.sv
src/fixed_length_frame_matcher.sv
tb/tb.sv
